// ===== rtl/qdd_pkg.sv =====
// Package for the quadrature decoder with detents.
// Item structs, step and detent codes, Gray-code tables. No dependencies.
package qdd_pkg;

    typedef struct packed {
        logic level_a;
        logic level_b;
        logic confirm_a;
        logic confirm_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] detent_count;
        logic [1:0]         step_kind;
        logic [1:0]         detent_event;
    } t_out_item;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_FWD  = 2'd1,
        STEP_BWD  = 2'd2,
        STEP_JUMP = 2'd3
    } t_step_kind;

    typedef enum logic [1:0] {
        DET_NONE = 2'd0,
        DET_UP   = 2'd1,
        DET_DOWN = 2'd2
    } t_detent_event;

    localparam logic [1:0] AB_00 = 2'b00;
    localparam logic [1:0] AB_01 = 2'b01;
    localparam logic [1:0] AB_11 = 2'b11;
    localparam logic [1:0] AB_10 = 2'b10;

    localparam logic [3:0] SPD_RESET = 4'd4;

    // Gray order 00 -> 01 -> 11 -> 10 -> 00
    function automatic logic [1:0] next_fwd(input logic [1:0] ab);
        logic [1:0] r;
        case (ab)
            AB_00:   r = AB_01;
            AB_01:   r = AB_11;
            AB_11:   r = AB_10;
            AB_10:   r = AB_00;
            default: r = AB_00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] next_bwd(input logic [1:0] ab);
        logic [1:0] r;
        case (ab)
            AB_00:   r = AB_10;
            AB_10:   r = AB_11;
            AB_11:   r = AB_01;
            AB_01:   r = AB_00;
            default: r = AB_00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/quadrature_decoder_with_detents.sv =====
// Quadrature decoder with detent counter, top level.
// Depends on qdd_pkg; checked by qdd_checker (bound from its own file).
//
// One sample item in, one result item out, one item per clock unless stalled.
// Each accepted sample is decoded in the cycle it is accepted: the confirmed
// A/B state is compared against the last stable state, the position counter
// steps by one on a Gray step, and the detent counter moves when the distance
// from the last detent reaches steps_per_detent (0 is taken as 1). All
// counters are COUNT_WIDTH bits and wrap; outputs are sign-extended or
// truncated to 32 bits. Results go into a two-entry output queue, so an item
// is taken while a finished result waits; o_in_stall rises only when both
// entries are full. Each result is registered into the queue. The distance
// to the last detent is held directly as a counter rather than as a
// reference position, so the per-item logic is one increment or decrement,
// one negate and two compares. steps_per_detent resets to 4; the user must
// write it via i_cfg_wr_en/i_cfg_wr_data only while idle (not enforced).
module quadrature_decoder_with_detents #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  qdd_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output qdd_pkg::t_out_item o_out,
    input  logic               i_out_stall,
    input  logic               i_cfg_wr_en,
    input  logic [3:0]         i_cfg_wr_data
);
    import qdd_pkg::*;

    localparam int W = COUNT_WIDTH;

    // decoder state
    logic [1:0]          r_ab,   n_ab;
    logic signed [W-1:0] r_pos,  n_pos;
    logic signed [W-1:0] r_diff, n_diff;   // position - reference
    logic signed [W-1:0] r_det,  n_det;
    logic [3:0]          r_spd;

    // output queue
    t_out_item  r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;

    logic          push, pop;
    logic [1:0]    ab;
    logic          agree, changed, fwd, bwd;
    logic [W-1:0]  diff_step, diff_neg, spd_w;
    logic          up, down;
    t_step_kind    kind;
    t_detent_event evt;
    t_out_item     res;

    assign push = i_in_valid && !o_in_stall;
    assign pop  = o_out_valid && !i_out_stall;

    always_comb begin
        ab      = {i_in.level_a, i_in.level_b};
        agree   = (i_in.level_a == i_in.confirm_a) && (i_in.level_b == i_in.confirm_b);
        changed = agree && (ab != r_ab);
        fwd     = changed && (next_fwd(r_ab) == ab);
        bwd     = changed && (next_bwd(r_ab) == ab);
        spd_w   = (r_spd == 4'd0) ? W'(1) : W'(r_spd);

        n_ab  = changed ? ab : r_ab;
        n_pos = r_pos;
        diff_step = W'(r_diff);
        if (fwd) begin
            n_pos     = r_pos + W'(1);
            diff_step = W'(r_diff) + W'(1);
        end else if (bwd) begin
            n_pos     = r_pos - W'(1);
            diff_step = W'(r_diff) - W'(1);
        end
        diff_neg = W'(0) - diff_step;
        // most negative distance wraps to itself, still >= spd unsigned
        up   = (fwd || bwd) && !diff_step[W-1] && (diff_step >= spd_w);
        down = (fwd || bwd) &&  diff_step[W-1] && (diff_neg  >= spd_w);

        n_det  = r_det;
        n_diff = signed'(diff_step);
        if (up) begin
            n_det  = r_det + W'(1);
            n_diff = '0;
        end else if (down) begin
            n_det  = r_det - W'(1);
            n_diff = '0;
        end
    end

    always_comb begin
        if (!changed)  kind = STEP_NONE;
        else if (fwd)  kind = STEP_FWD;
        else if (bwd)  kind = STEP_BWD;
        else           kind = STEP_JUMP;

        if (up)        evt = DET_UP;
        else if (down) evt = DET_DOWN;
        else           evt = DET_NONE;

        res.position     = 32'(n_pos);
        res.detent_count = 32'(n_det);
        res.step_kind    = kind;
        res.detent_event = evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab   <= AB_00;
            r_pos  <= '0;
            r_diff <= '0;
            r_det  <= '0;
            r_spd  <= SPD_RESET;
        end else begin
            if (i_cfg_wr_en) r_spd <= i_cfg_wr_data;
            if (push) begin
                r_ab   <= n_ab;
                r_pos  <= n_pos;
                r_diff <= n_diff;
                r_det  <= n_det;
            end
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= res;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_q[r_rd];

endmodule

// ===== rtl/qdd_checker.sv =====
// Port-level checker for quadrature_decoder_with_detents, bound below.
// Depends on qdd_pkg.
module qdd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input qdd_pkg::t_out_item o_out,
    input logic               i_out_stall
);
    import qdd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("stalled result changed");

    // detent only moves on a counted step
    a_evt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.detent_event != DET_NONE) |->
            (o_out.step_kind == STEP_FWD) || (o_out.step_kind == STEP_BWD))
        else $error("detent event without a step");

    // input side only backs up when a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

endmodule

bind quadrature_decoder_with_detents qdd_checker u_qdd_checker (.*);
